/* hdl/stereo_surge_ducking_dynamics_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stereo surge ducking dynamics core
// Immediate-cycle and next-cycle implication checks, clocked on clk and
// disabled while rst is high. Defining ASSERT_OFF removes all of them.
// ----------------------------------------------------------------------------
`ifndef STEREO_SURGE_DUCKING_DYNAMICS_CORE_ASSERT_SVH
`define STEREO_SURGE_DUCKING_DYNAMICS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// cons must hold in the same cycle as ante
`define SSDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define SSDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SSDD_ASSERT_NOW(lbl, ante, cons, msg)
`define SSDD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/ssdd_pkg.sv */
// ----------------------------------------------------------------------------
// ssdd_pkg
// Widths, register indexes, operation codes and the controller command
// bundle shared by the surge ducking dynamics core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 17;
  localparam int STEP_W     = 32;
  localparam int RATE_W     = 19;

  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd4;

  // envelope state
  localparam int ACCEL_W   = 34;
  localparam int LEVEL_W   = 41;
  localparam int SENSE_W   = 44;
  localparam int LVL_Q24_W = LEVEL_W - 16;

  localparam logic [GAIN_W-1:0]  ONE_Q16 = 17'h1_0000;
  localparam logic [LEVEL_W-1:0] ONE_Q40 = 41'h100_0000_0000;

  // channel datapath
  localparam int C_W    = SAMPLE_BITS + 4;
  localparam int WETV_W = SAMPLE_BITS + 5;
  localparam int MIX_W  = SAMPLE_BITS + 21;

  // shared multiplier: signed A times unsigned B
  localparam int MA_W = (SAMPLE_BITS + 5 > ACCEL_W) ? SAMPLE_BITS + 5 : ACCEL_W;
  localparam int MB_W = LVL_Q24_W + 1;
  localparam int P_W  = MA_W + MB_W;

  // detector alignment to Q40
  localparam int SENSE_SH  = 28 - SAMPLE_BITS;
  localparam int SENSE_SHL = (SENSE_SH > 0) ? SENSE_SH : 0;
  localparam int SENSE_SHR = (SENSE_SH < 0) ? -SENSE_SH : 0;

  // sequencer
  localparam int STEP_CNT_W = 4;
  localparam int OP_W       = 4;

  localparam logic [OP_W-1:0] MUL_NONE       = 4'd0;
  localparam logic [OP_W-1:0] MUL_PEAK_GAIN  = 4'd1;
  localparam logic [OP_W-1:0] MUL_XL_GAIN    = 4'd2;
  localparam logic [OP_W-1:0] MUL_XR_GAIN    = 4'd3;
  localparam logic [OP_W-1:0] MUL_ACCEL_RATE = 4'd4;
  localparam logic [OP_W-1:0] MUL_SLOPE_RATE = 4'd5;
  localparam logic [OP_W-1:0] MUL_C1L_GAIN   = 4'd6;
  localparam logic [OP_W-1:0] MUL_C1R_GAIN   = 4'd7;
  localparam logic [OP_W-1:0] MUL_C2L_LVL    = 4'd8;
  localparam logic [OP_W-1:0] MUL_C2R_LVL    = 4'd9;
  localparam logic [OP_W-1:0] MUL_XL_DRY     = 4'd10;
  localparam logic [OP_W-1:0] MUL_XR_DRY     = 4'd11;
  localparam logic [OP_W-1:0] MUL_WETVL_WET  = 4'd12;
  localparam logic [OP_W-1:0] MUL_WETVR_WET  = 4'd13;

  localparam logic [OP_W-1:0] WB_NONE  = 4'd0;
  localparam logic [OP_W-1:0] WB_ACCEL = 4'd1;
  localparam logic [OP_W-1:0] WB_SLOPE = 4'd2;
  localparam logic [OP_W-1:0] WB_LEVEL = 4'd3;
  localparam logic [OP_W-1:0] WB_C1L   = 4'd4;
  localparam logic [OP_W-1:0] WB_C1R   = 4'd5;
  localparam logic [OP_W-1:0] WB_C2L   = 4'd6;
  localparam logic [OP_W-1:0] WB_C2R   = 4'd7;
  localparam logic [OP_W-1:0] WB_CONTL = 4'd8;
  localparam logic [OP_W-1:0] WB_CONTR = 4'd9;
  localparam logic [OP_W-1:0] WB_ACC   = 4'd10;
  localparam logic [OP_W-1:0] WB_MIXL  = 4'd11;
  localparam logic [OP_W-1:0] WB_MIXR  = 4'd12;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] mul_op;
    logic [OP_W-1:0] wb_op;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/stereo_surge_ducking_dynamics_core.sv */
// ----------------------------------------------------------------------------
// stereo_surge_ducking_dynamics_core
// Stereo ducking processor with a second-order envelope chase.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one stereo frame per transfer, left and right signed
//   24-bit samples. Output stream m_*: the processed pair, one result per
//   input frame, in order.
//   Config port: cfg_we writes cfg_data into register cfg_index on the clock
//   edge (0 intensity, 1 wet_mix, 2 attack_step, 3 decay_step, 4 rate_gain).
//   Write only while no frame is in flight; other indexes are ignored.
// Schedule:
//   After the accept cycle a frame runs 14 steps of the single shared 34x26
//   multiplier, which does 13 products per frame. m_tvalid rises once the last
//   step writes the output register. s_tready is high whenever no frame is
//   being processed, so the next frame is taken while a result still waits.
// Stall:
//   If the previous result has not been taken when a frame reaches its last
//   step, that step holds until m_tready frees the output register.
// Reset:
//   rst (synchronous) returns the registers to their defaults and zeroes the
//   envelope acceleration, slope and level; no frame or result survives.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_surge_ducking_dynamics_core import ssdd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,   // [23:0] left_sample, [47:24] right_sample
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,   // [23:0] left_result, [47:24] right_result
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t                   cmd;
  logic [SAMPLE_BITS-1:0] left_result;
  logic [SAMPLE_BITS-1:0] right_result;

  // sequencer: owns both handshakes and the output-valid flag
  ssdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // datapath: config, envelope state, shared multiplier, output register
  ssdd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_left   (s_tdata[SAMPLE_BITS-1:0]),
    .in_right  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .out_left  (left_result),
    .out_right (right_result)
  );

  assign m_tdata = DATA_W'({right_result, left_result});

endmodule

`default_nettype wire

/* hdl/ssdd_ctrl.sv */
// ----------------------------------------------------------------------------
// ssdd_ctrl
// Sequencer: takes an input transfer, walks the fixed multiply schedule and
// hands the finished pair to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_surge_ducking_dynamics_core_assert.svh"

module ssdd_ctrl import ssdd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(13);

  logic [0:0]            state;
  logic [STEP_CNT_W-1:0] step;
  logic                  out_valid;

  logic accept;
  logic out_free;
  logic at_last;

  assign accept   = s_tvalid && (state == ST_IDLE);
  assign out_free = !out_valid || m_tready;
  assign at_last  = (state == ST_RUN) && (step == STEP_LAST);

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // schedule: steps 0 to 12 each issue one multiply, steps 1 to 13 retire the previous one
  always_comb begin
    cmd.load   = accept;
    cmd.mul_op = MUL_NONE;
    cmd.wb_op  = WB_NONE;
    if (state == ST_RUN) begin
      unique case (step)
        4'd0:  begin cmd.mul_op = MUL_PEAK_GAIN;  cmd.wb_op = WB_NONE;  end
        4'd1:  begin cmd.mul_op = MUL_XL_GAIN;    cmd.wb_op = WB_ACCEL; end
        4'd2:  begin cmd.mul_op = MUL_ACCEL_RATE; cmd.wb_op = WB_C1L;   end
        4'd3:  begin cmd.mul_op = MUL_XR_GAIN;    cmd.wb_op = WB_SLOPE; end
        4'd4:  begin cmd.mul_op = MUL_SLOPE_RATE; cmd.wb_op = WB_C1R;   end
        4'd5:  begin cmd.mul_op = MUL_C1L_GAIN;   cmd.wb_op = WB_LEVEL; end
        4'd6:  begin cmd.mul_op = MUL_C1R_GAIN;   cmd.wb_op = WB_C2L;   end
        4'd7:  begin cmd.mul_op = MUL_C2L_LVL;    cmd.wb_op = WB_C2R;   end
        4'd8:  begin cmd.mul_op = MUL_C2R_LVL;    cmd.wb_op = WB_CONTL; end
        4'd9:  begin cmd.mul_op = MUL_XL_DRY;     cmd.wb_op = WB_CONTR; end
        4'd10: begin cmd.mul_op = MUL_WETVL_WET;  cmd.wb_op = WB_ACC;   end
        4'd11: begin cmd.mul_op = MUL_XR_DRY;     cmd.wb_op = WB_MIXL;  end
        4'd12: begin cmd.mul_op = MUL_WETVR_WET;  cmd.wb_op = WB_ACC;   end
        4'd13: begin cmd.mul_op = MUL_NONE;       cmd.wb_op = WB_MIXR;  end
        default: begin end
      endcase
    end
    // hold the final step while the previous result is still unclaimed
    if (at_last && !out_free) begin
      cmd.wb_op = WB_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (step == STEP_LAST) begin
            if (out_free) begin
              state <= ST_IDLE;
              step  <= '0;
            end
          end else begin
            step <= step + STEP_CNT_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (at_last && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SSDD_ASSERT_NOW(a_no_overwrite, cmd.wb_op == WB_MIXR, !out_valid || m_tready, "result overwritten")
  `SSDD_ASSERT_NEXT(a_start, accept, state == ST_RUN && step == '0, "run did not start")
  `SSDD_ASSERT_NEXT(a_finish, at_last && out_free, m_tvalid && state == ST_IDLE, "result lost")
  `SSDD_ASSERT_NOW(a_idle_quiet, state == ST_IDLE, cmd.mul_op == MUL_NONE && cmd.wb_op == WB_NONE, "idle cmd")

endmodule

`default_nettype wire

/* hdl/ssdd_datapath.sv */
// ----------------------------------------------------------------------------
// ssdd_datapath
// Configuration registers, envelope chase state, shared multiplier and the
// per-channel ducking and mix arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdd_datapath import ssdd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0] in_left,
  input  logic [SAMPLE_BITS-1:0] in_right,
  output logic [SAMPLE_BITS-1:0] out_left,
  output logic [SAMPLE_BITS-1:0] out_right
);

  localparam int ACC_SUM_W   = ACCEL_W + 1;
  localparam int SLOPE_SUM_W = ACCEL_W + 4;
  localparam int LVL_SUM_W   = LEVEL_W + 2;

  localparam logic signed [P_W-1:0]   RND_13  = P_W'(4096);
  localparam logic signed [P_W-1:0]   RND_16  = P_W'(32768);
  localparam logic signed [P_W-1:0]   RND_24  = P_W'(8388608);
  localparam logic signed [MIX_W-1:0] RND_MIX = MIX_W'(32768);
  localparam logic signed [MIX_W-1:0] SAT_MAX = MIX_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [MIX_W-1:0] SAT_MIN = -SAT_MAX - MIX_W'(1);

  // configuration
  logic [GAIN_W-1:0] intensity;
  logic [GAIN_W-1:0] wet_mix;
  logic [STEP_W-1:0] attack_step;
  logic [STEP_W-1:0] decay_step;
  logic [RATE_W-1:0] rate_gain;

  // chase state
  logic signed [ACCEL_W-1:0] accel;
  logic signed [ACCEL_W-1:0] slope;
  logic [LEVEL_W-1:0]        level;

  // working registers
  logic signed [SAMPLE_BITS-1:0] x_l;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [C_W-1:0]         c1_l;
  logic signed [C_W-1:0]         c1_r;
  logic signed [C_W-1:0]         c2_l;
  logic signed [C_W-1:0]         c2_r;
  logic signed [WETV_W-1:0]      wetv_l;
  logic signed [WETV_W-1:0]      wetv_r;
  logic signed [MIX_W-1:0]       acc;
  logic [SAMPLE_BITS-1:0]        res_l;
  logic signed [P_W-1:0]         prod;

  // combinational
  logic [GAIN_W-1:0]       gain;
  logic [GAIN_W-1:0]       wet;
  logic [GAIN_W-1:0]       dry;
  logic [SAMPLE_BITS-1:0]  abs_l;
  logic [SAMPLE_BITS-1:0]  abs_r;
  logic [SAMPLE_BITS-1:0]  peak;
  logic signed [MA_W-1:0]  op_a;
  logic [MB_W-2:0]         op_b;

  logic [P_W-1:0]          prod_u;
  logic [P_W-1:0]          sense_full;
  logic [SENSE_W-1:0]      sense;
  logic [SENSE_W-1:0]      level_ext;
  logic signed [ACC_SUM_W-1:0] att_pos;
  logic signed [ACC_SUM_W-1:0] dec_pos;
  logic signed [ACC_SUM_W-1:0] accel_sum;
  logic signed [ACC_SUM_W-1:0] accel_clamp;

  logic signed [P_W-1:0]         prod_q16;
  logic signed [SLOPE_SUM_W-1:0] slope_sum;
  logic signed [SLOPE_SUM_W-1:0] slope_clamp;
  logic signed [SLOPE_SUM_W-1:0] slope_hi;
  logic signed [SLOPE_SUM_W-1:0] slope_lo;
  logic signed [LVL_SUM_W-1:0]   level_sum;
  logic [LEVEL_W-1:0]            level_clamp;

  logic signed [P_W-1:0]    prod_r13;
  logic signed [P_W-1:0]    prod_r16;
  logic signed [P_W-1:0]    prod_r24;
  logic signed [C_W-1:0]    c1_new;
  logic signed [C_W-1:0]    c2_new;
  logic signed [C_W-1:0]    content;
  logic signed [WETV_W-1:0] wetv_l_new;
  logic signed [WETV_W-1:0] wetv_r_new;
  logic signed [MIX_W-1:0]  mix_sum;
  logic signed [MIX_W-1:0]  mix_rnd;
  logic [SAMPLE_BITS-1:0]   mix_sat;

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity   <= GAIN_W'(32768);
      wet_mix     <= ONE_Q16;
      attack_step <= STEP_W'(219902326);
      decay_step  <= STEP_W'(16547650);
      rate_gain   <= RATE_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTENSITY:   intensity   <= cfg_data[GAIN_W-1:0];
        REG_WET_MIX:     wet_mix     <= cfg_data[GAIN_W-1:0];
        REG_ATTACK_STEP: attack_step <= cfg_data[STEP_W-1:0];
        REG_DECAY_STEP:  decay_step  <= cfg_data[STEP_W-1:0];
        REG_RATE_GAIN:   rate_gain   <= cfg_data[RATE_W-1:0];
        default: begin end
      endcase
    end
  end

  // ---- operand selection ----
  assign gain  = (intensity > ONE_Q16) ? ONE_Q16 : intensity;
  assign wet   = (wet_mix > ONE_Q16) ? ONE_Q16 : wet_mix;
  assign dry   = ONE_Q16 - wet;
  assign abs_l = x_l[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_l) : SAMPLE_BITS'(x_l);
  assign abs_r = x_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_r) : SAMPLE_BITS'(x_r);
  assign peak  = (abs_r > abs_l) ? abs_r : abs_l;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_op)
      MUL_PEAK_GAIN:  begin op_a = MA_W'($signed({1'b0, peak})); op_b = (MB_W-1)'(gain); end
      MUL_XL_GAIN:    begin op_a = MA_W'(x_l);    op_b = (MB_W-1)'(gain);      end
      MUL_XR_GAIN:    begin op_a = MA_W'(x_r);    op_b = (MB_W-1)'(gain);      end
      MUL_ACCEL_RATE: begin op_a = MA_W'(accel);  op_b = (MB_W-1)'(rate_gain); end
      MUL_SLOPE_RATE: begin op_a = MA_W'(slope);  op_b = (MB_W-1)'(rate_gain); end
      MUL_C1L_GAIN:   begin op_a = MA_W'(c1_l);   op_b = (MB_W-1)'(gain);      end
      MUL_C1R_GAIN:   begin op_a = MA_W'(c1_r);   op_b = (MB_W-1)'(gain);      end
      MUL_C2L_LVL:    begin op_a = MA_W'(c2_l);   op_b = level[LEVEL_W-1:16];  end
      MUL_C2R_LVL:    begin op_a = MA_W'(c2_r);   op_b = level[LEVEL_W-1:16];  end
      MUL_XL_DRY:     begin op_a = MA_W'(x_l);    op_b = (MB_W-1)'(dry);       end
      MUL_XR_DRY:     begin op_a = MA_W'(x_r);    op_b = (MB_W-1)'(dry);       end
      MUL_WETVL_WET:  begin op_a = MA_W'(wetv_l); op_b = (MB_W-1)'(wet);       end
      MUL_WETVR_WET:  begin op_a = MA_W'(wetv_r); op_b = (MB_W-1)'(wet);       end
      default: begin end
    endcase
  end

  // shared multiplier, result registered
  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod <= op_a * $signed({1'b0, op_b});
    end
  end

  // ---- envelope chase ----
  assign prod_u     = prod;
  assign sense_full = (prod_u << SENSE_SHL) >> SENSE_SHR;
  assign sense      = sense_full[SENSE_W-1:0];
  assign level_ext  = SENSE_W'(level);
  assign att_pos    = $signed({{(ACC_SUM_W-STEP_W){1'b0}}, attack_step});
  assign dec_pos    = $signed({{(ACC_SUM_W-STEP_W){1'b0}}, decay_step});

  always_comb begin
    priority if (level_ext < sense) begin
      accel_sum = ACC_SUM_W'(accel) + att_pos;
    end else if (level_ext > sense) begin
      accel_sum = ACC_SUM_W'(accel) - dec_pos;
    end else begin
      accel_sum = ACC_SUM_W'(accel);
    end
    priority if (accel_sum > dec_pos) begin
      accel_clamp = dec_pos;
    end else if (accel_sum < -att_pos) begin
      accel_clamp = -att_pos;
    end else begin
      accel_clamp = accel_sum;
    end
  end

  assign prod_q16  = prod >>> 16;
  assign slope_hi  = SLOPE_SUM_W'(dec_pos);
  assign slope_lo  = -SLOPE_SUM_W'(att_pos);
  assign slope_sum = SLOPE_SUM_W'(slope) + SLOPE_SUM_W'(prod_q16);
  assign level_sum = LVL_SUM_W'($signed({1'b0, level})) + LVL_SUM_W'(prod_q16);

  always_comb begin
    priority if (slope_sum > slope_hi) begin
      slope_clamp = slope_hi;
    end else if (slope_sum < slope_lo) begin
      slope_clamp = slope_lo;
    end else begin
      slope_clamp = slope_sum;
    end
    priority if (level_sum > LVL_SUM_W'($signed({1'b0, ONE_Q40}))) begin
      level_clamp = ONE_Q40;
    end else if (level_sum < LVL_SUM_W'(0)) begin
      level_clamp = '0;
    end else begin
      level_clamp = level_sum[LEVEL_W-1:0];
    end
  end

  // ---- channel arithmetic (round half up) ----
  assign prod_r13   = (prod + RND_13) >>> 13;
  assign prod_r16   = (prod + RND_16) >>> 16;
  assign prod_r24   = (prod + RND_24) >>> 24;
  assign c1_new     = C_W'(prod_r13);
  assign c2_new     = C_W'(prod_r16);
  assign content    = C_W'(prod_r24);
  assign wetv_l_new = WETV_W'(x_l) - WETV_W'(content);
  assign wetv_r_new = WETV_W'(x_r) - WETV_W'(content);
  assign mix_sum    = acc + MIX_W'(prod);
  assign mix_rnd    = (mix_sum + RND_MIX) >>> 16;

  always_comb begin
    priority if (mix_rnd > SAT_MAX) begin
      mix_sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (mix_rnd < SAT_MIN) begin
      mix_sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      mix_sat = mix_rnd[SAMPLE_BITS-1:0];
    end
  end

  // ---- state writeback ----
  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= '0;
      slope <= '0;
      level <= '0;
    end else begin
      unique case (cmd.wb_op)
        WB_ACCEL: accel <= ACCEL_W'(accel_clamp);
        WB_SLOPE: slope <= ACCEL_W'(slope_clamp);
        WB_LEVEL: level <= level_clamp;
        default: begin end
      endcase
    end
  end

  // ---- payload writeback ----
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_l <= in_left;
      x_r <= in_right;
    end
    unique case (cmd.wb_op)
      WB_C1L:   c1_l   <= c1_new;
      WB_C1R:   c1_r   <= c1_new;
      WB_C2L:   c2_l   <= c2_new;
      WB_C2R:   c2_r   <= c2_new;
      WB_CONTL: wetv_l <= wetv_l_new;
      WB_CONTR: wetv_r <= wetv_r_new;
      WB_ACC:   acc    <= MIX_W'(prod);
      WB_MIXL:  res_l  <= mix_sat;
      WB_MIXR: begin
        out_left  <= res_l;
        out_right <= mix_sat;
      end
      default: begin end
    endcase
  end

endmodule

`default_nettype wire

/* verif/tb_stereo_surge_ducking_dynamics_core.sv */
// ----------------------------------------------------------------------------
// tb_stereo_surge_ducking_dynamics_core
// Self-checking bench for the stereo ducking core. A bit-true predictor of
// the envelope chase and the two channel paths runs on every accepted input
// transfer; each output transfer is checked against the oldest prediction.
// Directed tests cover silence, full-scale extremes, gain above one, zero
// rate and a pinned envelope; random phases cover the rest, mostly under random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stereo_surge_ducking_dynamics_core;
  import ssdd_pkg::*;

  localparam int  IDLE_PCT       = 6;     // idle cycles per hundred, each side
  localparam int  RESULT_LATENCY = 16;    // accept and every sequencer step, plus margin
  localparam int  WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int  RANDOM_PHASES  = 6;
  localparam int  PHASE_ITEMS    = 100;
  localparam int  MAX_REPORTS    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_RATE_GAIN + 1'b1;

  localparam logic [SAMPLE_BITS-1:0] S_MAX  = 24'h7F_FFFF;
  localparam logic [SAMPLE_BITS-1:0] S_MIN  = 24'h80_0000;
  localparam logic [SAMPLE_BITS-1:0] S_ZERO = 24'h00_0000;

  localparam longint SAT_HI    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO    = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam longint LEVEL_TOP = longint'(1) << 40;
  localparam longint GAIN_TOP  = 65536;
  // peak at which the detector equals a pinned level when intensity is one
  localparam logic [SAMPLE_BITS-1:0] S_AT_TOP = 24'h10_0000;

  typedef enum int {STYLE_NOISE, STYLE_LOUD, STYLE_QUIET, STYLE_SILENT} burst_style_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata   = '0;   // [23:0] left_sample, [47:24] right_sample
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [DATA_W-1:0]     m_tdata;          // [23:0] left_result, [47:24] right_result
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  stereo_surge_ducking_dynamics_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: shadow registers and envelope state, all arithmetic in longint
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] shadow_intensity;
  logic [GAIN_W-1:0] shadow_wet;
  logic [STEP_W-1:0] shadow_attack;
  logic [STEP_W-1:0] shadow_decay;
  logic [RATE_W-1:0] shadow_rate;
  longint            env_accel;
  longint            env_slope;
  longint            env_level;

  logic [DATA_W-1:0] duck_expect_q[$];   // predicted output frames, oldest first
  int                mismatch_count = 0;
  bit                send_idle_on   = 1'b1;
  bit                recv_idle_on   = 1'b1;

  function automatic void reset_shadow();
    shadow_intensity = 17'd32768;
    shadow_wet       = 17'd65536;
    shadow_attack    = 32'd219902326;
    shadow_decay     = 32'd16547650;
    shadow_rate      = 19'd65536;
    env_accel        = 0;
    env_slope        = 0;
    env_level        = 0;
  endfunction

  // floor division by 2^n after adding half: rounds half toward +inf
  function automatic longint round_half_up(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // one channel: dry minus ducked content, wet/dry blend, 24-bit saturation
  function automatic logic [SAMPLE_BITS-1:0] duck_channel(longint x, longint g, longint w);
    longint c1, c2, ducked, blend;
    c1     = round_half_up(x * 8 * g, 16);
    c2     = round_half_up(c1 * g, 16);
    ducked = round_half_up(c2 * (env_level >>> 16), 24);
    blend  = round_half_up(x * (GAIN_TOP - w) + (x - ducked) * w, 16);
    blend  = clamp_to(blend, SAT_LO, SAT_HI);
    return blend[SAMPLE_BITS-1:0];
  endfunction

  // advances the envelope by one frame and returns the expected output frame
  function automatic logic [DATA_W-1:0] duck_frame(logic [SAMPLE_BITS-1:0] left,
                                                   logic [SAMPLE_BITS-1:0] right);
    longint xl, xr, g, w, att, dec, rate, peak, peak_r, detect;
    logic [SAMPLE_BITS-1:0] out_l, out_r;
    xl   = longint'($signed(left));
    xr   = longint'($signed(right));
    g    = (shadow_intensity > ONE_Q16) ? GAIN_TOP : longint'(shadow_intensity);
    w    = (shadow_wet > ONE_Q16) ? GAIN_TOP : longint'(shadow_wet);
    att  = longint'(shadow_attack);
    dec  = longint'(shadow_decay);
    rate = longint'(shadow_rate);

    peak   = (xl < 0) ? -xl : xl;
    peak_r = (xr < 0) ? -xr : xr;
    if (peak_r > peak) peak = peak_r;
    detect = (peak * g) << (28 - SAMPLE_BITS);

    // equal level and detector leaves the acceleration alone
    if (env_level < detect) env_accel = env_accel + att;
    if (env_level > detect) env_accel = env_accel - dec;
    env_accel = clamp_to(env_accel, -att, dec);
    env_slope = clamp_to(env_slope + ((env_accel * rate) >>> 16), -att, dec);
    env_level = clamp_to(env_level + ((env_slope * rate) >>> 16), 0, LEVEL_TOP);

    out_l = duck_channel(xl, g, w);
    out_r = duck_channel(xr, g, w);
    return {out_r, out_l};
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: m_tready drops at random; handshakes are sampled at the falling
  // edge, where everything that the next rising edge sees is already stable
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= !rst && !(recv_idle_on && ($urandom_range(99) < IDLE_PCT));
  end

  task automatic note_mismatch(input string what, input logic [SAMPLE_BITS-1:0] want,
                               input logic [SAMPLE_BITS-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d (0x%06h), got %0d (0x%06h)",
               what, $signed(want), want, $signed(got), got);
  endtask

  always @(negedge clk) begin : check_results
    logic [DATA_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (duck_expect_q.size() == 0) begin
        note_mismatch("unexpected result transfer", '0, m_tdata[SAMPLE_BITS-1:0]);
      end else begin
        want = duck_expect_q.pop_front();
        if (m_tdata[SAMPLE_BITS-1:0] !== want[SAMPLE_BITS-1:0])
          note_mismatch("left_result", want[SAMPLE_BITS-1:0], m_tdata[SAMPLE_BITS-1:0]);
        if (m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want[2*SAMPLE_BITS-1:SAMPLE_BITS])
          note_mismatch("right_result", want[2*SAMPLE_BITS-1:SAMPLE_BITS],
                        m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      end
    end
  end

  // watchdog: too long without a transfer on either stream ends the run
  int quiet_cycles = 0;
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. All tasks return right after a rising edge, so each drives
  // its NBAs in a fresh time step. send_frame leaves s_tvalid high after the
  // transfer; whoever lets time pass next either replaces the frame or lowers it.
  // --------------------------------------------------------------------------
  task automatic send_frame(input logic [SAMPLE_BITS-1:0] left,
                            input logic [SAMPLE_BITS-1:0] right);
    logic taken;
    while (send_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      s_tvalid <= 1'b0;
      s_tdata  <= DATA_W'({$urandom, $urandom});
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {right, left};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    duck_expect_q.push_back(duck_frame(left, right));
  endtask

  // hold the input until every outstanding result has been taken
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (duck_expect_q.size() != 0) @(posedge clk);
  endtask

  // fully idle: results drained plus the pipeline latency
  task automatic settle_block();
    wait_results_drained();
    repeat (RESULT_LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_INTENSITY:   shadow_intensity = data[GAIN_W-1:0];
      REG_WET_MIX:     shadow_wet       = data[GAIN_W-1:0];
      REG_ATTACK_STEP: shadow_attack    = data[STEP_W-1:0];
      REG_DECAY_STEP:  shadow_decay     = data[STEP_W-1:0];
      REG_RATE_GAIN:   shadow_rate      = data[RATE_W-1:0];
      default: ;
    endcase
  endtask

  // writes every register (raw 32-bit data, upper bits ignored by the core),
  // plus one write to an unused index that must change nothing
  task automatic apply_config(input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] wet,
                              input logic [CFG_DATA_W-1:0] att, input logic [CFG_DATA_W-1:0] dec,
                              input logic [CFG_DATA_W-1:0] rate);
    settle_block();
    write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(2)), $urandom);
    write_reg(REG_INTENSITY, gain);
    write_reg(REG_WET_MIX, wet);
    write_reg(REG_ATTACK_STEP, att);
    write_reg(REG_DECAY_STEP, dec);
    write_reg(REG_RATE_GAIN, rate);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random content
  // --------------------------------------------------------------------------
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(burst_style_t style);
    logic [SAMPLE_BITS-1:0] mag;
    logic [31:0]            r;
    r = $urandom;
    case (style)
      STYLE_LOUD: begin
        if (r[7:0] == 8'd0) return r[8] ? S_MIN : S_MAX;
        mag = SAMPLE_BITS'($urandom_range(8388607, 4194304));
        return r[31] ? -mag : mag;
      end
      STYLE_QUIET: begin
        mag = SAMPLE_BITS'($urandom_range(4095));
        return r[31] ? -mag : mag;
      end
      STYLE_SILENT: return S_ZERO;
      default: return r[SAMPLE_BITS-1:0];
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain_reg();
    logic [GAIN_W-1:0]            v;
    logic [CFG_DATA_W-GAIN_W-1:0] upper;
    upper = (CFG_DATA_W-GAIN_W)'($urandom);
    case ($urandom_range(4))
      0:       v = '0;
      1:       v = ONE_Q16;
      2:       v = GAIN_W'($urandom_range(131071, 65537));   // above one
      default: v = GAIN_W'($urandom_range(65536));
    endcase
    return {upper, v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step_reg();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(32'h1000_0000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rate_reg();
    logic [RATE_W-1:0]            v;
    logic [CFG_DATA_W-RATE_W-1:0] upper;
    upper = (CFG_DATA_W-RATE_W)'($urandom);
    case ($urandom_range(5))
      0:       v = '0;              // frozen envelope
      1:       v = 19'd8192;
      2:       v = 19'd262144;
      3:       v = '1;
      default: v = RATE_W'($urandom_range(262144, 8192));
    endcase
    return {upper, v};
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset defaults: silence at zero level (level equals detector), extremes
  task automatic test_silence_and_extremes();
    send_frame(S_ZERO, S_ZERO);
    send_frame(S_ZERO, S_ZERO);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_ZERO);
    send_frame(S_ZERO, S_MAX);
    send_frame(24'h00_0001, 24'hFF_FFFF);
    send_frame(24'hFF_FFFF, 24'h00_0001);
    send_frame(24'h55_5555, 24'hAA_AAAA);
    send_frame(S_ZERO, S_ZERO);
  endtask

  // intensity and wet above one saturate to one; steps at their extremes
  task automatic test_gain_above_one();
    int i;
    apply_config(32'hFFFF_FFFF, 32'h0001_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0007_FFFF);
    for (i = 0; i < 8; i++) send_frame(pick_sample(STYLE_LOUD), pick_sample(STYLE_LOUD));
    for (i = 0; i < 3; i++) send_frame(S_ZERO, S_ZERO);
  endtask

  // zero rate freezes slope and level; zero intensity and zero wet
  task automatic test_zero_rate();
    int i;
    apply_config(32'd0, 32'd0, 32'd219902326, 32'd16547650, 32'd0);
    for (i = 0; i < 3; i++) send_frame(pick_sample(STYLE_LOUD), pick_sample(STYLE_NOISE));
    apply_config(32'd65536, 32'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    for (i = 0; i < 3; i++) send_frame(pick_sample(STYLE_LOUD), pick_sample(STYLE_LOUD));
  endtask

  // drive the level to its ceiling, hold it there with a detector exactly at
  // one, then let it fall away through silence
  task automatic test_level_at_top();
    int i;
    apply_config(32'd65536, 32'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd262144);
    for (i = 0; i < 80; i++) send_frame(pick_sample(STYLE_LOUD), pick_sample(STYLE_LOUD));
    for (i = 0; i < 6; i++) send_frame(i[0] ? S_AT_TOP : -S_AT_TOP, S_ZERO);
    wait_results_drained();
    for (i = 0; i < 30; i++) send_frame(S_ZERO, S_ZERO);
  endtask

  // random configs; bursts of loud, quiet, silent and noisy frames so the
  // envelope attacks and releases; pause mid-phase until fully drained
  task automatic test_random_bursts();
    int           phase, sent, run;
    burst_style_t style;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_config(pick_gain_reg(), pick_gain_reg(), pick_step_reg(), pick_step_reg(),
                   pick_rate_reg());
      // one phase runs with no idling on either side
      send_idle_on = (phase != 2);
      recv_idle_on = (phase != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        style = burst_style_t'($urandom_range(3));
        run   = $urandom_range(40, 5);
        while (run > 0 && sent < PHASE_ITEMS) begin
          send_frame(pick_sample(style), pick_sample(style));
          sent++;
          run--;
          if (sent == PHASE_ITEMS / 2) wait_results_drained();
        end
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_silence_and_extremes();
    test_gain_above_one();
    test_zero_rate();
    test_level_at_top();
    test_random_bursts();

    settle_block();
    if (mismatch_count == 0 && duck_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
